// ===== design/edps_pkg.sv =====
// Shared types and constants for the encoder drive PID step unit.
`timescale 1ns / 1ps
`default_nettype none

package edps_pkg;

    localparam int SUM_WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH    = 16;

    localparam logic [14:0]        TARGET_RESET  = 15'd0;
    localparam logic [7:0]         GAIN_RESET    = 8'd0;
    localparam logic signed [1:0]  HEADING_RESET = 2'sd1;
    localparam logic [15:0]        TIMEOUT_RESET = 16'd0;
    localparam logic [6:0]         LIMIT_RESET   = 7'd90;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TARGET  = 3'd0,
        CFG_GAIN_P  = 3'd1,
        CFG_GAIN_I  = 3'd2,
        CFG_GAIN_D  = 3'd3,
        CFG_HEADING = 3'd4,
        CFG_TIMEOUT = 3'd5,
        CFG_LIMIT   = 3'd6
    } t_cfg_index;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } t_command;

    typedef struct packed {
        logic               command;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0]  drive_power;
        logic               running;
        logic signed [15:0] position_error;
    } t_out_beat;

    typedef struct packed {
        logic restart;
        logic running;
    } t_mid_ctrl;

    typedef struct packed {
        logic [7:0]        gain_p;
        logic [7:0]        gain_i;
        logic [7:0]        gain_d;
        logic signed [1:0] heading_sign;
        logic [6:0]        output_limit;
    } t_pwr_cfg;

endpackage

`default_nettype wire

// ===== design/encoder_drive_pid_step_unit.sv =====
// Top level of the encoder drive PID step unit: registers, handshake and stages.
`timescale 1ns / 1ps
`default_nettype none

// Discrete clamped PID step for a two-encoder drive. Each input beat is either a
// restart (clears error sum, last error and period count) or one sample of the two
// relative encoder counts; every beat gives exactly one result beat. Three register
// stages: input register, error/sum stage (holds the loop state), power stage
// (three gain products, clamp, direction). A beat passes through the stages in that order,
// each handing it on only when the next stage is free. One beat is accepted per
// cycle while the output is taken; each stage drains independently, so up to three
// beats are held while a result waits at the output before the input stalls.
// Configuration writes take effect on the next cycle; write only while idle.
module encoder_drive_pid_step_unit import edps_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire t_in_beat                   i_in_beat,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output t_out_beat                       o_out_beat
);

    logic [14:0]        r_target;
    logic [15:0]        r_timeout;
    t_pwr_cfg           r_pwr_cfg;

    logic               r_in_valid;
    t_in_beat           r_in_beat;
    logic               r_mid_valid;
    logic               r_out_valid;

    logic               w_out_free;
    logic               w_mid_free;
    logic               w_in_free;
    logic               w_mid_adv;
    logic               w_in_adv;

    t_mid_ctrl                   w_ctrl;
    logic signed [15:0]          w_err;
    logic signed [16:0]          w_diff;
    logic signed [SUM_WIDTH-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target               <= TARGET_RESET;
            r_timeout              <= TIMEOUT_RESET;
            r_pwr_cfg.gain_p       <= GAIN_RESET;
            r_pwr_cfg.gain_i       <= GAIN_RESET;
            r_pwr_cfg.gain_d       <= GAIN_RESET;
            r_pwr_cfg.heading_sign <= HEADING_RESET;
            r_pwr_cfg.output_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET:  r_target               <= i_cfg_data[14:0];
                CFG_GAIN_P:  r_pwr_cfg.gain_p       <= i_cfg_data[7:0];
                CFG_GAIN_I:  r_pwr_cfg.gain_i       <= i_cfg_data[7:0];
                CFG_GAIN_D:  r_pwr_cfg.gain_d       <= i_cfg_data[7:0];
                CFG_HEADING: r_pwr_cfg.heading_sign <= $signed(i_cfg_data[1:0]);
                CFG_TIMEOUT: r_timeout              <= i_cfg_data;
                CFG_LIMIT:   r_pwr_cfg.output_limit <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_mid_free = !r_mid_valid || w_out_free;
    assign w_in_free  = !r_in_valid  || w_mid_free;
    assign w_mid_adv  = r_mid_valid && w_out_free;
    assign w_in_adv   = r_in_valid  && w_mid_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free)  r_in_valid  <= i_in_valid;
            if (w_mid_free) r_mid_valid <= r_in_valid;
            if (w_out_free) r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_free) begin
            r_in_beat <= i_in_beat;
        end
    end

    edps_err_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_err_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_in_adv),
        .i_beat    (r_in_beat),
        .i_target  (r_target),
        .i_timeout (r_timeout),
        .o_ctrl    (w_ctrl),
        .o_err     (w_err),
        .o_diff    (w_diff),
        .o_sum     (w_sum)
    );

    edps_pwr_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_pwr_stage (
        .i_clk  (i_clk),
        .i_adv  (w_mid_adv),
        .i_cfg  (r_pwr_cfg),
        .i_ctrl (w_ctrl),
        .i_err  (w_err),
        .i_diff (w_diff),
        .i_sum  (w_sum),
        .o_beat (o_out_beat)
    );

    assign o_in_ready  = w_in_free;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/edps_err_stage.sv =====
// Position, error, difference and saturating sum stage with the loop state.
`timescale 1ns / 1ps
`default_nettype none

module edps_err_stage import edps_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire t_in_beat                    i_beat,
    input  wire logic [14:0]                 i_target,
    input  wire logic [15:0]                 i_timeout,
    output t_mid_ctrl                        o_ctrl,
    output logic signed [15:0]               o_err,
    output logic signed [16:0]               o_diff,
    output logic signed [SUM_WIDTH-1:0]      o_sum
);

    logic signed [15:0]          r_prev_err;
    logic signed [SUM_WIDTH-1:0] r_acc;
    logic [15:0]                 r_count;

    t_mid_ctrl                   r_ctrl;
    logic signed [15:0]          r_err;
    logic signed [16:0]          r_diff;
    logic signed [SUM_WIDTH-1:0] r_sum;

    logic [15:0]                 w_mag_l;
    logic [15:0]                 w_mag_r;
    logic [16:0]                 w_pos_sum;
    logic [15:0]                 w_pos;
    logic signed [16:0]          w_err_wide;
    logic signed [15:0]          w_err;
    logic signed [16:0]          w_diff;
    logic signed [SUM_WIDTH:0]   w_sum_ext;
    logic signed [SUM_WIDTH-1:0] w_sum;
    logic                        w_restart;
    logic                        w_running;

    assign w_restart = (i_beat.command == CMD_RESTART);

    assign w_mag_l = i_beat.left_count[15]  ? $unsigned(-i_beat.left_count)
                                            : $unsigned(i_beat.left_count);
    assign w_mag_r = i_beat.right_count[15] ? $unsigned(-i_beat.right_count)
                                            : $unsigned(i_beat.right_count);
    assign w_pos_sum  = {1'b0, w_mag_l} + {1'b0, w_mag_r};
    assign w_pos      = w_pos_sum[16:1];
    assign w_err_wide = $signed({2'b00, i_target}) - $signed({1'b0, w_pos});
    assign w_err      = w_err_wide[15:0];
    assign w_diff     = $signed({w_err[15], w_err}) - $signed({r_prev_err[15], r_prev_err});

    assign w_sum_ext = $signed({r_acc[SUM_WIDTH-1], r_acc})
                     + $signed({{(SUM_WIDTH+1-16){w_err[15]}}, w_err});

    always_comb begin
        if (w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1]) begin
            w_sum = w_sum_ext[SUM_WIDTH]
                  ? $signed({1'b1, {(SUM_WIDTH-1){1'b0}}})
                  : $signed({1'b0, {(SUM_WIDTH-1){1'b1}}});
        end else begin
            w_sum = w_sum_ext[SUM_WIDTH-1:0];
        end
    end

    assign w_running = (r_count < i_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_acc      <= '0;
            r_count    <= '0;
            r_ctrl     <= '0;
        end else if (i_adv) begin
            if (w_restart) begin
                r_prev_err <= '0;
                r_acc      <= '0;
                r_count    <= '0;
                r_ctrl.running <= (i_timeout != 16'd0);
            end else begin
                if (w_running) begin
                    r_prev_err <= w_err;
                    r_acc      <= w_sum;
                    r_count    <= r_count + 16'd1;
                end
                r_ctrl.running <= w_running;
            end
            r_ctrl.restart <= w_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_err  <= w_err;
            r_diff <= w_diff;
            r_sum  <= w_sum;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_err  = r_err;
    assign o_diff = r_diff;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

// ===== design/edps_pwr_stage.sv =====
// Gain products, clamp and direction stage with the result register.
`timescale 1ns / 1ps
`default_nettype none

module edps_pwr_stage import edps_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_adv,
    input  wire t_pwr_cfg                    i_cfg,
    input  wire t_mid_ctrl                   i_ctrl,
    input  wire logic signed [15:0]          i_err,
    input  wire logic signed [16:0]          i_diff,
    input  wire logic signed [SUM_WIDTH-1:0] i_sum,
    output t_out_beat                        o_beat
);

    localparam int PW = SUM_WIDTH + 10;

    t_out_beat            r_beat;

    logic signed [PW-1:0] w_prod_p;
    logic signed [PW-1:0] w_prod_i;
    logic signed [PW-1:0] w_prod_d;
    logic signed [PW-1:0] w_power;
    logic signed [PW-1:0] w_lim;
    logic signed [PW-1:0] w_neg_lim;
    logic signed [7:0]    w_clamped;
    logic signed [7:0]    w_drive;
    t_out_beat            n_beat;

    assign w_prod_p = $signed({{(PW-8){1'b0}}, i_cfg.gain_p})
                    * $signed({{(PW-16){i_err[15]}}, i_err});
    assign w_prod_i = $signed({{(PW-8){1'b0}}, i_cfg.gain_i})
                    * $signed({{(PW-SUM_WIDTH){i_sum[SUM_WIDTH-1]}}, i_sum});
    assign w_prod_d = $signed({{(PW-8){1'b0}}, i_cfg.gain_d})
                    * $signed({{(PW-17){i_diff[16]}}, i_diff});
    assign w_power  = w_prod_p + w_prod_i + w_prod_d;

    assign w_lim     = $signed({{(PW-7){1'b0}}, i_cfg.output_limit});
    assign w_neg_lim = -w_lim;

    always_comb begin
        if (w_power > w_lim) begin
            w_clamped = w_lim[7:0];
        end else if (w_power < w_neg_lim) begin
            w_clamped = w_neg_lim[7:0];
        end else begin
            w_clamped = w_power[7:0];
        end

        if (i_cfg.heading_sign == 2'sd0) begin
            w_drive = 8'sd0;
        end else if (i_cfg.heading_sign[1]) begin
            w_drive = -w_clamped;
        end else begin
            w_drive = w_clamped;
        end
    end

    always_comb begin
        n_beat.running = i_ctrl.running;
        if (i_ctrl.restart) begin
            n_beat.drive_power    = 8'sd0;
            n_beat.position_error = 16'sd0;
        end else begin
            n_beat.drive_power    = i_ctrl.running ? w_drive : 8'sd0;
            n_beat.position_error = i_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ===== design/edps_checker.sv =====
// Port-level checks for the encoder drive PID step unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module edps_checker import edps_pkg::*; (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire t_in_beat                   i_in_beat,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire t_out_beat                  o_out_beat
);

    // offered input beat holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_beat))
        else $error("input beat dropped or changed while stalled");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat dropped or changed while stalled");

    // no power outside the run window
    a_idle_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.running |-> o_out_beat.drive_power == 8'sd0)
        else $error("drive power while not running");

    // clamp range is symmetric, most negative code never shows
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.drive_power != $signed(8'h80))
        else $error("drive power outside clamp range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind encoder_drive_pid_step_unit edps_checker u_edps_checker (.*);

`default_nettype wire
